### rtl/core/jcpt_pkg.sv
`default_nettype none

package jcpt_pkg;

  // number formats
  localparam int QUAT_FRAC_BITS = 14;
  localparam int QW             = 16;
  localparam int POS_W          = 32;

  // a rounded matrix entry: doubled exact sum of two quaternion products, then >> frac
  localparam int COEF_W  = 2 * QW + 2 - QUAT_FRAC_BITS;
  localparam int MUL_A_W = (COEF_W > QW) ? COEF_W : QW;
  localparam int PROD_W  = MUL_A_W + POS_W;
  localparam int ACC_W   = ((PROD_W + 3) > (POS_W + QUAT_FRAC_BITS + 3)) ?
                           (PROD_W + 3) : (POS_W + QUAT_FRAC_BITS + 3);

  localparam int N_COEF   = 9;
  localparam int COEF_IW  = $clog2(N_COEF);
  localparam int N_AXIS   = 3;
  localparam int AXIS_IW  = $clog2(N_AXIS);
  localparam int PROG_LEN = 35;
  localparam int PC_W     = $clog2(PROG_LEN);

  // matrix entry slots, row major
  localparam logic [COEF_IW-1:0] C11 = COEF_IW'(0);
  localparam logic [COEF_IW-1:0] C12 = COEF_IW'(1);
  localparam logic [COEF_IW-1:0] C13 = COEF_IW'(2);
  localparam logic [COEF_IW-1:0] C21 = COEF_IW'(3);
  localparam logic [COEF_IW-1:0] C22 = COEF_IW'(4);
  localparam logic [COEF_IW-1:0] C23 = COEF_IW'(5);
  localparam logic [COEF_IW-1:0] C31 = COEF_IW'(6);
  localparam logic [COEF_IW-1:0] C32 = COEF_IW'(7);
  localparam logic [COEF_IW-1:0] C33 = COEF_IW'(8);

  localparam logic [AXIS_IW-1:0] AX_X = AXIS_IW'(0);
  localparam logic [AXIS_IW-1:0] AX_Y = AXIS_IW'(1);
  localparam logic [AXIS_IW-1:0] AX_Z = AXIS_IW'(2);

  // multiplier operand a
  typedef enum logic [2:0] {
    A_W, A_X, A_Y, A_Z, A_C
  } a_sel_t;

  // multiplier operand b
  typedef enum logic [2:0] {
    B_W, B_X, B_Y, B_Z, B_PX, B_PY, B_PZ
  } b_sel_t;

  typedef enum logic [2:0] {
    ACC_NOP, ACC_LD, ACC_ADD, ACC_SUB, ACC_LDT
  } acc_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_COEF, WR_COEF2, WR_ROW, WR_ROWZ, WR_EMIT
  } wr_t;

  typedef enum logic [1:0] {
    FL_NEXT, FL_END_NLAST, FL_EMIT_END
  } flow_t;

  typedef struct packed {
    a_sel_t              a_sel;
    logic [COEF_IW-1:0]  a_idx;
    b_sel_t              b_sel;
  } mul_ctl_t;

  typedef struct packed {
    acc_op_t             acc_op;
    logic [AXIS_IW-1:0]  t_idx;
    wr_t                 wr;
    logic [COEF_IW-1:0]  wr_idx;
  } act_t;

  typedef struct packed {
    mul_ctl_t mul;
    act_t     act;
    flow_t    flow;
  } ucw_t;

  localparam act_t ACT_NOP = '{acc_op: ACC_NOP, t_idx: AX_X, wr: WR_NONE, wr_idx: C11};

  function automatic ucw_t mk(input a_sel_t a, input logic [COEF_IW-1:0] ai,
                              input b_sel_t b, input acc_op_t op,
                              input logic [AXIS_IW-1:0] ti, input wr_t wr,
                              input logic [COEF_IW-1:0] wi, input flow_t fl);
    ucw_t u;
    u.mul.a_sel  = a;
    u.mul.a_idx  = ai;
    u.mul.b_sel  = b;
    u.act.acc_op = op;
    u.act.t_idx  = ti;
    u.act.wr     = wr;
    u.act.wr_idx = wi;
    u.flow       = fl;
    return u;
  endfunction

  // microprogram: the multiply is issued at the step, the action lands in the next cycle
  function automatic ucw_t jcpt_ucode(input logic [PC_W-1:0] pc);
    ucw_t u;
    u = mk(A_W, C11, B_W, ACC_NOP, AX_X, WR_NONE, C11, FL_NEXT);
    unique case (pc)
      // c11 = ww + xx - yy - zz
      PC_W'(0):  u = mk(A_W, C11, B_W,  ACC_LD,  AX_X, WR_NONE,  C11, FL_NEXT);
      PC_W'(1):  u = mk(A_X, C11, B_X,  ACC_ADD, AX_X, WR_NONE,  C11, FL_NEXT);
      PC_W'(2):  u = mk(A_Y, C11, B_Y,  ACC_SUB, AX_X, WR_NONE,  C11, FL_NEXT);
      PC_W'(3):  u = mk(A_Z, C11, B_Z,  ACC_SUB, AX_X, WR_NONE,  C11, FL_NEXT);
      // c12 = 2(xy - wz)
      PC_W'(4):  u = mk(A_X, C11, B_Y,  ACC_LD,  AX_X, WR_COEF,  C11, FL_NEXT);
      PC_W'(5):  u = mk(A_W, C11, B_Z,  ACC_SUB, AX_X, WR_NONE,  C11, FL_NEXT);
      // c13 = 2(wy + xz)
      PC_W'(6):  u = mk(A_W, C11, B_Y,  ACC_LD,  AX_X, WR_COEF2, C12, FL_NEXT);
      PC_W'(7):  u = mk(A_X, C11, B_Z,  ACC_ADD, AX_X, WR_NONE,  C11, FL_NEXT);
      // c21 = 2(wz + xy)
      PC_W'(8):  u = mk(A_W, C11, B_Z,  ACC_LD,  AX_X, WR_COEF2, C13, FL_NEXT);
      PC_W'(9):  u = mk(A_X, C11, B_Y,  ACC_ADD, AX_X, WR_NONE,  C11, FL_NEXT);
      // c22 = ww - xx + yy - zz
      PC_W'(10): u = mk(A_W, C11, B_W,  ACC_LD,  AX_X, WR_COEF2, C21, FL_NEXT);
      PC_W'(11): u = mk(A_X, C11, B_X,  ACC_SUB, AX_X, WR_NONE,  C11, FL_NEXT);
      PC_W'(12): u = mk(A_Y, C11, B_Y,  ACC_ADD, AX_X, WR_NONE,  C11, FL_NEXT);
      PC_W'(13): u = mk(A_Z, C11, B_Z,  ACC_SUB, AX_X, WR_NONE,  C11, FL_NEXT);
      // c23 = 2(yz - wx)
      PC_W'(14): u = mk(A_Y, C11, B_Z,  ACC_LD,  AX_X, WR_COEF,  C22, FL_NEXT);
      PC_W'(15): u = mk(A_W, C11, B_X,  ACC_SUB, AX_X, WR_NONE,  C11, FL_NEXT);
      // c31 = 2(xz - wy)
      PC_W'(16): u = mk(A_X, C11, B_Z,  ACC_LD,  AX_X, WR_COEF2, C23, FL_NEXT);
      PC_W'(17): u = mk(A_W, C11, B_Y,  ACC_SUB, AX_X, WR_NONE,  C11, FL_NEXT);
      // c32 = 2(wx + yz)
      PC_W'(18): u = mk(A_W, C11, B_X,  ACC_LD,  AX_X, WR_COEF2, C31, FL_NEXT);
      PC_W'(19): u = mk(A_Y, C11, B_Z,  ACC_ADD, AX_X, WR_NONE,  C11, FL_NEXT);
      // c33 = ww - xx - yy + zz
      PC_W'(20): u = mk(A_W, C11, B_W,  ACC_LD,  AX_X, WR_COEF2, C32, FL_NEXT);
      PC_W'(21): u = mk(A_X, C11, B_X,  ACC_SUB, AX_X, WR_NONE,  C11, FL_NEXT);
      PC_W'(22): u = mk(A_Y, C11, B_Y,  ACC_SUB, AX_X, WR_NONE,  C11, FL_NEXT);
      PC_W'(23): u = mk(A_Z, C11, B_Z,  ACC_ADD, AX_X, WR_NONE,  C11, FL_NEXT);
      // x row
      PC_W'(24): u = mk(A_C, C11, B_PX, ACC_LDT, AX_X, WR_COEF,  C33, FL_NEXT);
      PC_W'(25): u = mk(A_C, C12, B_PY, ACC_ADD, AX_X, WR_NONE,  C11, FL_NEXT);
      PC_W'(26): u = mk(A_C, C13, B_PZ, ACC_ADD, AX_X, WR_NONE,  C11, FL_NEXT);
      // y row
      PC_W'(27): u = mk(A_C, C21, B_PX, ACC_LDT, AX_Y, WR_ROW,   C11, FL_NEXT);
      PC_W'(28): u = mk(A_C, C22, B_PY, ACC_ADD, AX_X, WR_NONE,  C11, FL_NEXT);
      PC_W'(29): u = mk(A_C, C23, B_PZ, ACC_ADD, AX_X, WR_NONE,  C11, FL_NEXT);
      // z row
      PC_W'(30): u = mk(A_C, C31, B_PX, ACC_LDT, AX_Z, WR_ROW,   C12, FL_NEXT);
      PC_W'(31): u = mk(A_C, C32, B_PY, ACC_ADD, AX_X, WR_NONE,  C11, FL_NEXT);
      PC_W'(32): u = mk(A_C, C33, B_PZ, ACC_ADD, AX_X, WR_NONE,  C11, FL_NEXT);
      // commit the new point, stop here unless the chain ends
      PC_W'(33): u = mk(A_W, C11, B_W,  ACC_NOP, AX_X, WR_ROWZ,  C11, FL_END_NLAST);
      PC_W'(34): u = mk(A_W, C11, B_W,  ACC_NOP, AX_X, WR_EMIT,  C11, FL_EMIT_END);
      default:   u = mk(A_W, C11, B_W,  ACC_NOP, AX_X, WR_NONE,  C11, FL_EMIT_END);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

### rtl/core/jcpt_in_if.sv
`default_nettype none

interface jcpt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [jcpt_pkg::QW-1:0]      rot_w;
  logic signed [jcpt_pkg::QW-1:0]      rot_x;
  logic signed [jcpt_pkg::QW-1:0]      rot_y;
  logic signed [jcpt_pkg::QW-1:0]      rot_z;
  logic signed [jcpt_pkg::POS_W-1:0]   off_x;
  logic signed [jcpt_pkg::POS_W-1:0]   off_y;
  logic signed [jcpt_pkg::POS_W-1:0]   off_z;
  logic                                last_in_chain;

  modport source (
    output valid, rot_w, rot_x, rot_y, rot_z, off_x, off_y, off_z, last_in_chain,
    input  ready
  );
  modport sink (
    input  valid, rot_w, rot_x, rot_y, rot_z, off_x, off_y, off_z, last_in_chain,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/jcpt_out_if.sv
`default_nettype none

interface jcpt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [jcpt_pkg::POS_W-1:0]   pos_x;
  logic signed [jcpt_pkg::POS_W-1:0]   pos_y;
  logic signed [jcpt_pkg::POS_W-1:0]   pos_z;
  logic                                saturated;

  modport source (
    output valid, pos_x, pos_y, pos_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, saturated,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/jcpt_seq.sv
`default_nettype none

module jcpt_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic               in_last,
  input  wire logic               out_busy,
  output logic                    in_ready,
  output jcpt_pkg::mul_ctl_t      mul_ctl,
  output jcpt_pkg::act_t          act
);
  import jcpt_pkg::*;

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            last_r;
  act_t            act_r, act_nxt;
  ucw_t            word;

  assign word     = jcpt_ucode(pc_r);
  assign mul_ctl  = word.mul;
  assign act      = act_r;
  assign in_ready = ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
      act_r  <= ACT_NOP;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      act_r  <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      last_r <= in_last;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    act_nxt  = ACT_NOP;
    if (!busy_r) begin
      if (in_fire) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
      end
    end else begin
      act_nxt = word.act;
      unique case (word.flow)
        FL_NEXT: begin
          pc_nxt = pc_r + PC_W'(1);
        end
        FL_END_NLAST: begin
          if (last_r) begin
            pc_nxt = pc_r + PC_W'(1);
          end else begin
            busy_nxt = 1'b0;
          end
        end
        FL_EMIT_END: begin
          // hold until the result register is free
          if (out_busy) begin
            act_nxt = ACT_NOP;
          end else begin
            busy_nxt = 1'b0;
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/jcpt_dp.sv
`default_nettype none

module jcpt_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_fire,
  input  wire logic signed [jcpt_pkg::QW-1:0]      rot_w,
  input  wire logic signed [jcpt_pkg::QW-1:0]      rot_x,
  input  wire logic signed [jcpt_pkg::QW-1:0]      rot_y,
  input  wire logic signed [jcpt_pkg::QW-1:0]      rot_z,
  input  wire logic signed [jcpt_pkg::POS_W-1:0]   off_x,
  input  wire logic signed [jcpt_pkg::POS_W-1:0]   off_y,
  input  wire logic signed [jcpt_pkg::POS_W-1:0]   off_z,
  input  wire jcpt_pkg::mul_ctl_t                  mul_ctl,
  input  wire jcpt_pkg::act_t                      act,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic signed [jcpt_pkg::POS_W-1:0]        pos_x,
  output logic signed [jcpt_pkg::POS_W-1:0]        pos_y,
  output logic signed [jcpt_pkg::POS_W-1:0]        pos_z,
  output logic                                     saturated,
  output logic                                     out_busy
);
  import jcpt_pkg::*;

  localparam logic signed [ACC_W-1:0] RND     = ACC_W'(1) << (QUAT_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] POS_MAX = {{(ACC_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] POS_MIN = {{(ACC_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] SAT_HI  = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] SAT_LO  = {1'b1, {(POS_W-1){1'b0}}};

  // captured item
  logic signed [QW-1:0]     qw_r, qx_r, qy_r, qz_r;
  logic signed [POS_W-1:0]  t_r [N_AXIS];

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [POS_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   prod_ext, t_ext;
  logic signed [COEF_W-1:0]  coef_r [N_COEF];

  logic signed [ACC_W-1:0]   coef_v, coef_sum, coef_sh;
  logic signed [ACC_W-1:0]   row_sum, row_sh;
  logic signed [POS_W-1:0]   row_val;
  logic                      row_sat;

  // point being built, and the committed point
  logic signed [POS_W-1:0]   n_r [2];
  logic signed [POS_W-1:0]   px_r, py_r, pz_r;
  logic                      sat_r;

  logic                      out_valid_r;
  logic signed [POS_W-1:0]   ox_r, oy_r, oz_r;
  logic                      osat_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      qw_r      <= rot_w;
      qx_r      <= rot_x;
      qy_r      <= rot_y;
      qz_r      <= rot_z;
      t_r[AX_X] <= off_x;
      t_r[AX_Y] <= off_y;
      t_r[AX_Z] <= off_z;
    end
  end

  // shared multiplier operands
  always_comb begin
    case (mul_ctl.a_sel)
      A_W:     mul_a = MUL_A_W'(qw_r);
      A_X:     mul_a = MUL_A_W'(qx_r);
      A_Y:     mul_a = MUL_A_W'(qy_r);
      A_Z:     mul_a = MUL_A_W'(qz_r);
      A_C:     mul_a = MUL_A_W'(coef_r[mul_ctl.a_idx]);
      default: mul_a = '0;
    endcase
    case (mul_ctl.b_sel)
      B_W:     mul_b = POS_W'(qw_r);
      B_X:     mul_b = POS_W'(qx_r);
      B_Y:     mul_b = POS_W'(qy_r);
      B_Z:     mul_b = POS_W'(qz_r);
      B_PX:    mul_b = px_r;
      B_PY:    mul_b = py_r;
      B_PZ:    mul_b = pz_r;
      default: mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
  end

  assign prod_ext = ACC_W'(prod_r);
  assign t_ext    = ACC_W'(t_r[act.t_idx]) <<< QUAT_FRAC_BITS;

  always_comb begin
    case (act.acc_op)
      ACC_LD:  acc_nxt = prod_ext;
      ACC_ADD: acc_nxt = acc_r + prod_ext;
      ACC_SUB: acc_nxt = acc_r - prod_ext;
      ACC_LDT: acc_nxt = t_ext + prod_ext;
      default: acc_nxt = acc_r;
    endcase
  end

  // matrix entry: optional doubling, round half up
  assign coef_v   = (act.wr == WR_COEF2) ? (acc_r <<< 1) : acc_r;
  assign coef_sum = coef_v + RND;
  assign coef_sh  = coef_sum >>> QUAT_FRAC_BITS;

  // coordinate: round half up, clamp to 32 bits
  assign row_sum = acc_r + RND;
  assign row_sh  = row_sum >>> QUAT_FRAC_BITS;

  always_comb begin
    row_sat = 1'b1;
    if (row_sh > POS_MAX) begin
      row_val = SAT_HI;
    end else if (row_sh < POS_MIN) begin
      row_val = SAT_LO;
    end else begin
      row_val = row_sh[POS_W-1:0];
      row_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((act.wr == WR_COEF) || (act.wr == WR_COEF2)) begin
      coef_r[act.wr_idx] <= coef_sh[COEF_W-1:0];
    end
    if (act.wr == WR_ROW) begin
      n_r[act.wr_idx[0]] <= row_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r        <= '0;
      py_r        <= '0;
      pz_r        <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (act.wr)
        WR_ROW: begin
          sat_r <= sat_r | row_sat;
        end
        WR_ROWZ: begin
          px_r  <= n_r[0];
          py_r  <= n_r[1];
          pz_r  <= row_val;
          sat_r <= sat_r | row_sat;
        end
        WR_EMIT: begin
          out_valid_r <= 1'b1;
          px_r        <= '0;
          py_r        <= '0;
          pz_r        <= '0;
          sat_r       <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (act.wr == WR_EMIT) begin
      ox_r   <= px_r;
      oy_r   <= py_r;
      oz_r   <= pz_r;
      osat_r <= sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign pos_x     = ox_r;
  assign pos_y     = oy_r;
  assign pos_z     = oz_r;
  assign saturated = osat_r;
  assign out_busy  = out_valid_r & ~out_ready;

endmodule

`default_nettype wire

### rtl/core/joint_chain_point_transform_top.sv
`default_nettype none

// channel   dir  handshake     payload
// in_ch     in   valid/ready   rot_w rot_x rot_y rot_z off_x off_y off_z last_in_chain
// out_ch    out  valid/ready   pos_x pos_y pos_z saturated
//
// one request at a time: ready stays low while a joint is processed, the last joint of a
// chain taking an extra emit step; the single 20x32 multiplier does one product a cycle
// (24 quaternion products per matrix, squares taken again for each diagonal entry,
// 9 for the point)
// rst_n is synchronous: point and saturation flag return to zero, no result pending
// a result waits in an output register; only the emit step stalls on out_ch.ready

module joint_chain_point_transform_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  jcpt_in_if.sink     in_ch,
  jcpt_out_if.source  out_ch
);
  import jcpt_pkg::*;

  logic     in_fire;
  logic     in_ready;
  logic     out_busy;
  mul_ctl_t mul_ctl;
  act_t     act;

  // request accepted when both sides agree
  assign in_fire     = in_ch.valid & in_ready;
  assign in_ch.ready = in_ready;

  // microprogram sequencer: step counter, control word table, branch on end of chain
  jcpt_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_last  (in_ch.last_in_chain),
    .out_busy (out_busy),
    .in_ready (in_ready),
    .mul_ctl  (mul_ctl),
    .act      (act)
  );

  // datapath: shared multiplier, accumulator, matrix entries, point and result
  jcpt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rot_w     (in_ch.rot_w),
    .rot_x     (in_ch.rot_x),
    .rot_y     (in_ch.rot_y),
    .rot_z     (in_ch.rot_z),
    .off_x     (in_ch.off_x),
    .off_y     (in_ch.off_y),
    .off_z     (in_ch.off_z),
    .mul_ctl   (mul_ctl),
    .act       (act),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .pos_x     (out_ch.pos_x),
    .pos_y     (out_ch.pos_y),
    .pos_z     (out_ch.pos_z),
    .saturated (out_ch.saturated),
    .out_busy  (out_busy)
  );

endmodule

`default_nettype wire

### verif/joint_chain_point_transform_top_tb.sv
`timescale 1ns / 1ps

module joint_chain_point_transform_top_tb;
  import jcpt_pkg::*;

  // number formats and handy constants
  localparam int ONE_Q   = 1 << QUAT_FRAC_BITS;      // 1.0 in quaternion format
  localparam int COS45_Q = 11585;                    // cos(45 deg) in quaternion format
  localparam int ONE_M   = 1 << 16;                  // 1.0 m in position format
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam longint I32_MAX  = 64'sd2147483647;
  localparam longint I32_MIN  = -64'sd2147483648;
  localparam int     SETTLE_CYCLES = 64;             // more than one last-joint pass
  localparam int     HOLD_CYCLES   = 600;            // long output stall
  localparam longint LIMIT_NS      = 15_000_000;

  // one joint transform request
  typedef struct packed {
    logic signed [QW-1:0]    w, x, y, z;
    logic signed [POS_W-1:0] tx, ty, tz;
    logic                    last;
  } joint_t;

  // one chain result
  typedef struct packed {
    logic signed [POS_W-1:0] px, py, pz;
    logic                    sat;
  } point_t;

  logic clk = 1'b0;
  logic rst_n;

  jcpt_in_if  in_ch();
  jcpt_out_if out_ch();

  joint_chain_point_transform_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // traffic shaping, in percent per cycle
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned sink_hold_left = 0;

  // predicted chain state: point carried so far and its saturation flag
  longint chain_pt [3] = '{0, 0, 0};
  bit     chain_sat    = 1'b0;

  // points still to come out, oldest first
  point_t expected_points [$];

  int n_joints     = 0;
  int n_points     = 0;
  int n_sat_points = 0;
  int n_errors     = 0;

  // round half up to the quaternion fraction width
  function automatic longint round_quat(input longint v);
    return (v + (64'sd1 <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
  endfunction

  // apply one joint to the predicted point; queue the point when the chain ends
  task automatic advance_chain(input joint_t j);
    longint qw, qx, qy, qz;
    longint rot [9];
    longint trans [3];
    longint next_pt [3];
    point_t pt;
    qw = longint'($signed(j.w));
    qx = longint'($signed(j.x));
    qy = longint'($signed(j.y));
    qz = longint'($signed(j.z));
    trans[0] = longint'($signed(j.tx));
    trans[1] = longint'($signed(j.ty));
    trans[2] = longint'($signed(j.tz));
    // rotation matrix, row major, each entry rounded on its own
    rot[0] = round_quat(qw*qw + qx*qx - qy*qy - qz*qz);
    rot[1] = round_quat(2 * (qx*qy - qw*qz));
    rot[2] = round_quat(2 * (qw*qy + qx*qz));
    rot[3] = round_quat(2 * (qw*qz + qx*qy));
    rot[4] = round_quat(qw*qw - qx*qx + qy*qy - qz*qz);
    rot[5] = round_quat(2 * (qy*qz - qw*qx));
    rot[6] = round_quat(2 * (qx*qz - qw*qy));
    rot[7] = round_quat(2 * (qw*qx + qy*qz));
    rot[8] = round_quat(qw*qw - qx*qx - qy*qy + qz*qz);
    // new point from the old one, exact sum then one rounding and a clamp
    for (int i = 0; i < 3; i++) begin
      next_pt[i] = round_quat(rot[3*i] * chain_pt[0] + rot[3*i+1] * chain_pt[1] +
                              rot[3*i+2] * chain_pt[2] + (trans[i] <<< QUAT_FRAC_BITS));
      if (next_pt[i] > I32_MAX) begin
        next_pt[i] = I32_MAX;
        chain_sat  = 1'b1;
      end else if (next_pt[i] < I32_MIN) begin
        next_pt[i] = I32_MIN;
        chain_sat  = 1'b1;
      end
    end
    chain_pt = next_pt;
    if (j.last) begin
      pt.px  = chain_pt[0][POS_W-1:0];
      pt.py  = chain_pt[1][POS_W-1:0];
      pt.pz  = chain_pt[2][POS_W-1:0];
      pt.sat = chain_sat;
      expected_points = {expected_points, pt};
      chain_pt  = '{0, 0, 0};
      chain_sat = 1'b0;
    end
  endtask

  function automatic joint_t make_joint(input int w, x, y, z,
                                        input logic signed [POS_W-1:0] tx, ty, tz,
                                        input logic last);
    joint_t j;
    j.w    = QW'(w);
    j.x    = QW'(x);
    j.y    = QW'(y);
    j.z    = QW'(z);
    j.tx   = tx;
    j.ty   = ty;
    j.tz   = tz;
    j.last = last;
    return j;
  endfunction

  // random joint: mostly near-unit rotations and short offsets; junk is fully random
  function automatic joint_t random_joint(input bit junk);
    joint_t j;
    int unsigned mode;
    int ax, ay, az, rest;
    mode = junk ? 99 : $urandom_range(99);
    if (mode < 60) begin
      // unit quaternion: pick the vector part, solve for the scalar part
      ax   = int'($urandom_range(18000)) - 9000;
      ay   = int'($urandom_range(18000)) - 9000;
      az   = int'($urandom_range(18000)) - 9000;
      rest = ONE_Q * ONE_Q - ax*ax - ay*ay - az*az;
      j.w  = QW'($rtoi($sqrt(real'(rest))));
      if ($urandom_range(1) == 1) j.w = -j.w;
      j.x  = QW'(ax);
      j.y  = QW'(ay);
      j.z  = QW'(az);
    end else if (mode < 85) begin
      // anywhere in the nominal range, scales as well as rotates
      j.w = QW'(int'($urandom_range(2 * ONE_Q)) - ONE_Q);
      j.x = QW'(int'($urandom_range(2 * ONE_Q)) - ONE_Q);
      j.y = QW'(int'($urandom_range(2 * ONE_Q)) - ONE_Q);
      j.z = QW'(int'($urandom_range(2 * ONE_Q)) - ONE_Q);
    end else begin
      // any 16-bit pattern, out-of-range parts included
      j.w = QW'($urandom);
      j.x = QW'($urandom);
      j.y = QW'($urandom);
      j.z = QW'($urandom);
    end
    if (junk || $urandom_range(9) < 3) begin
      j.tx = $urandom;
      j.ty = $urandom;
      j.tz = $urandom;
    end else begin
      // up to 64 meters either way
      j.tx = int'($urandom_range(1 << 23)) - (1 << 22);
      j.ty = int'($urandom_range(1 << 23)) - (1 << 22);
      j.tz = int'($urandom_range(1 << 23)) - (1 << 22);
    end
    j.last = 1'b0;
    return j;
  endfunction

  task automatic drive_joint(input joint_t j);
    in_ch.rot_w         <= j.w;
    in_ch.rot_x         <= j.x;
    in_ch.rot_y         <= j.y;
    in_ch.rot_z         <= j.z;
    in_ch.off_x         <= j.tx;
    in_ch.off_y         <= j.ty;
    in_ch.off_z         <= j.tz;
    in_ch.last_in_chain <= j.last;
  endtask

  // offer one request, possibly after some idle cycles, and wait for it to be taken;
  // valid stays high on exit so back-to-back requests never drop it
  task automatic send_joint(input joint_t j);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    drive_joint(j);
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_joints++;
    advance_chain(j);
  endtask

  task automatic compare_field(input string name, input logic signed [POS_W-1:0] want, got);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_point();
    point_t want;
    if (expected_points.size() == 0) begin
      n_errors++;
      $display("%0t: point (%0d, %0d, %0d) sat %0b with none expected", $time,
               out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.saturated);
    end else begin
      want = expected_points.pop_front();
      n_points++;
      if (want.sat) n_sat_points++;
      compare_field("pos_x", want.px, out_ch.pos_x);
      compare_field("pos_y", want.py, out_ch.pos_y);
      compare_field("pos_z", want.pz, out_ch.pos_z);
      compare_field("saturated", POS_W'(want.sat), POS_W'(out_ch.saturated));
    end
  endtask

  // result side: check on each accepted result, then pick ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_point();
    if (sink_hold_left != 0) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // long output stall, counted down on its own
  always @(posedge clk) begin
    if (sink_hold_left != 0) sink_hold_left <= sink_hold_left - 1;
  end

  // identity and half-turn rotations: with identity the point is just the offsets summed
  task automatic test_identity_and_offsets();
    send_joint(make_joint(ONE_Q, 0, 0, 0, ONE_M, -2 * ONE_M, POS_MAX, 1'b1));
    send_joint(make_joint(ONE_Q, 0, 0, 0, POS_MIN, 0, 1, 1'b1));
    // -1 is the same rotation as +1
    send_joint(make_joint(-ONE_Q, 0, 0, 0, 1, 2, 3, 1'b0));
    // half turn about z flips x and y
    send_joint(make_joint(0, 0, 0, ONE_Q, 5, 6, 7, 1'b1));
  endtask

  // quarter turns about each axis and a half turn about x, chained
  task automatic test_rotations();
    send_joint(make_joint(COS45_Q, COS45_Q, 0, 0, ONE_M, 0, 0, 1'b0));
    send_joint(make_joint(COS45_Q, 0, COS45_Q, 0, 0, ONE_M, 0, 1'b0));
    send_joint(make_joint(COS45_Q, 0, 0, COS45_Q, 0, 0, ONE_M, 1'b0));
    send_joint(make_joint(0, ONE_Q, 0, 0, ONE_M / 2, -ONE_M / 3, 3, 1'b1));
    send_joint(make_joint(-COS45_Q, 0, -COS45_Q, 0, -ONE_M, 7, -ONE_M, 1'b1));
  endtask

  // clamping at both ends, flag held across the chain and cleared after it
  task automatic test_saturation();
    send_joint(make_joint(ONE_Q, 0, 0, 0, POS_MAX, POS_MAX, POS_MAX, 1'b0));
    send_joint(make_joint(ONE_Q, 0, 0, 0, POS_MAX, POS_MIN, 1, 1'b0));
    // zero rotation wipes the point but the flag must survive
    send_joint(make_joint(0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_joint(make_joint(ONE_Q, 0, 0, 0, POS_MIN, POS_MIN, POS_MIN, 1'b0));
    send_joint(make_joint(ONE_Q, 0, 0, 0, POS_MIN, -1, 0, 1'b1));
    send_joint(make_joint(ONE_Q, 0, 0, 0, 7, 8, 9, 1'b1));
  endtask

  // quaternions that are not unit length, out-of-range parts included
  task automatic test_odd_quaternions();
    send_joint(make_joint(0, 0, 0, 0, -ONE_M, ONE_M, 1, 1'b0));
    send_joint(make_joint(ONE_Q, ONE_Q, 0, 0, 3 * ONE_M, ONE_M, -ONE_M, 1'b1));
    send_joint(make_joint(-32768, -32768, -32768, -32768, ONE_M, ONE_M, ONE_M, 1'b0));
    send_joint(make_joint(-32768, 32767, -32768, 32767, -ONE_M, 2, POS_MAX, 1'b1));
    send_joint(make_joint(32767, -32768, 1, -1, 1, -1, 0, 1'b1));
  endtask

  // random chains; about one chain in ten is long, and about one in ten is junk
  task automatic test_random_chains(input int n_items, input int src_pct, input int sink_pct);
    joint_t j;
    int sent, len;
    bit junk;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      len  = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
      junk = ($urandom_range(9) == 0);
      for (int k = 0; k < len; k++) begin
        j      = random_joint(junk);
        j.last = (k == len - 1);
        send_joint(j);
      end
      sent += len;
    end
  endtask

  // hold the output off for a long time while requests keep coming, so the
  // pending result blocks the emit step and the input stalls behind it
  task automatic test_output_hold();
    joint_t j;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    sink_hold_left <= HOLD_CYCLES;
    for (int k = 0; k < 24; k++) begin
      j      = random_joint(1'b0);
      j.last = k[0];
      send_joint(j);
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    drive_joint('0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_identity_and_offsets();
    test_rotations();
    test_saturation();
    test_odd_quaternions();
    test_output_hold();
    test_random_chains(340, 0, 0);
    test_random_chains(340, 86, 0);
    test_random_chains(340, 0, 86);
    test_random_chains(340, 18, 18);

    // drain: wait for every point, then give the block time to show extras
    in_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("joint transforms sent: %0d; chain points checked: %0d, %0d of them clamped",
             n_joints, n_points, n_sat_points);
    $display("traffic: directed corners, long output stall, four random idle/stall mixes");
    if (n_errors == 0) begin
      $display("** joint_chain_point_transform_top: PASSED **");
    end else begin
      $display("** joint_chain_point_transform_top: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d points outstanding", expected_points.size());
    $display("** joint_chain_point_transform_top: FAILED **");
    $finish;
  end

endmodule
